/* hw/rtl/prl_pkg.sv */
// Package for the peer registry: table size, command and action codes, transfer structs.
package prl_pkg;

	// Table geometry
	localparam int NUM_SLOTS = 8;
	localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SLOT_W    = 5;
	localparam int CNT_W     = 6;

	typedef enum logic [1:0] {
		CMD_REGISTER = 2'd0,
		CMD_PRUNE    = 2'd1,
		CMD_LIST     = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_REFRESH = 3'd0,
		ACT_FILL    = 3'd1,
		ACT_EVICT   = 3'd2,
		ACT_PRUNE   = 3'd3,
		ACT_ENTRY   = 3'd4,
		ACT_EMPTY   = 3'd5
	} action_t;

	// One command transfer
	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] peer_ip;
		logic [31:0] now_ms;
	} req_t;

	// One result transfer
	typedef struct packed {
		logic [2:0]       action;
		logic [SLOT_W-1:0] slot;
		logic [31:0]      out_ip;
		logic [CNT_W-1:0] valid_count;
		logic             last;
	} rsp_t;

endpackage

/* hw/rtl/peer_registry_ttl_lru.sv */
// Peer registry top level: sequencer over a small table with one shared age/compare unit.
//
// Issue a command by raising start while busy is low; the command is taken at that edge.
// A sequencer then walks the slots one per cycle through a single age subtractor and
// its compares. Register scans every slot, or stops at slot i when a refresh matches
// it; prune scans every slot. List visits the slots in order, transfers one result
// per valid slot and stops after the last valid slot (an empty table gives one
// result). Command code 3 is dropped with no result and busy stays low. Each result
// is on rsp for exactly one cycle with rsp_valid high and cannot be held off, so the
// receiver must take it then. ttl is written through cfg_we/cfg_wdata; the user must
// write it only while no command is in flight, as the block itself does not enforce
// this. No clearing pass is needed after reset: valid bits clear at once.
module peer_registry_ttl_lru (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  prl_pkg::req_t       req,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	output logic                rsp_valid,
	output prl_pkg::rsp_t       rsp
);

	localparam int IW = prl_pkg::IDX_W;
	localparam int N  = prl_pkg::NUM_SLOTS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REG,
		S_PRUNE,
		S_LIST,
		S_EMIT
	} state_t;

	state_t                    state_q;
	logic [IW-1:0]             idx_q;
	logic [N-1:0]              valid_q;
	logic [31:0]               ttl_q;
	prl_pkg::req_t             req_q;
	logic                      free_found_q;
	logic [IW-1:0]             free_idx_q;
	logic [31:0]               best_q;
	logic [IW-1:0]             pick_q;
	prl_pkg::action_t          act_q;
	logic [IW-1:0]             slot_q;
	logic [31:0]               ip_q;
	logic                      rsp_valid_q;
	prl_pkg::rsp_t             rsp_q;

	logic [31:0]               addr_mem [N];
	logic [31:0]               seen_mem [N];

	logic [31:0]               cur_addr;
	logic [31:0]               cur_seen;
	logic [31:0]               age;
	logic                      expired;
	logic                      older;
	logic                      hit;
	logic                      is_free;
	logic                      last_idx;
	logic                      more_above;
	logic [prl_pkg::CNT_W-1:0] count;
	logic [IW-1:0]             choice;
	logic                      choice_free;
	logic                      wr_en;
	logic [IW-1:0]             wr_idx;

	// Shared age unit on the slot under the scan index
	always_comb begin
		cur_addr = addr_mem[idx_q];
		cur_seen = seen_mem[idx_q];
		age      = req_q.now_ms - cur_seen;
		expired  = age > ttl_q;
		older    = age > best_q;
		hit      = valid_q[idx_q] && (cur_addr == req_q.peer_ip);
		is_free  = !valid_q[idx_q] || expired;
		last_idx = (idx_q == IW'(N - 1));
	end

	// Count valid entries and look for valid ones past the scan index
	always_comb begin
		count      = '0;
		more_above = 1'b0;
		for (int j = 0; j < N; j++) begin
			count = count + prl_pkg::CNT_W'(valid_q[j]);
			if (valid_q[j] && (IW'(j) > idx_q)) begin
				more_above = 1'b1;
			end
		end
	end

	// Pick the replacement slot at the end of a register scan
	always_comb begin
		choice_free = free_found_q || is_free;
		if (free_found_q) begin
			choice = free_idx_q;
		end else if (is_free) begin
			choice = idx_q;
		end else if (older) begin
			choice = idx_q;
		end else begin
			choice = pick_q;
		end
		wr_en  = (state_q == S_REG) && (hit || last_idx);
		wr_idx = hit ? idx_q : choice;
	end

	// Table storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_mem[wr_idx] <= req_q.peer_ip;
			seen_mem[wr_idx] <= req_q.now_ms;
		end
	end

	// Command payload, held for the whole command
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
	end

	// Sequencer, valid bits and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			valid_q      <= '0;
			ttl_q        <= 32'd5000;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			best_q       <= '0;
			pick_q       <= '0;
			act_q        <= prl_pkg::ACT_REFRESH;
			slot_q       <= '0;
			ip_q         <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			rsp_valid_q <= 1'b0;
			if (cfg_we) begin
				ttl_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					idx_q        <= '0;
					free_found_q <= 1'b0;
					best_q       <= '0;
					pick_q       <= '0;
					if (start) begin
						priority if (req.cmd == prl_pkg::CMD_REGISTER) begin
							state_q <= S_REG;
						end else if (req.cmd == prl_pkg::CMD_PRUNE) begin
							state_q <= S_PRUNE;
						end else if (req.cmd == prl_pkg::CMD_LIST) begin
							if (valid_q == '0) begin
								act_q   <= prl_pkg::ACT_EMPTY;
								slot_q  <= '0;
								ip_q    <= '0;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_LIST;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_REG: begin
					// track first free slot and oldest slot while looking for a match
					if (is_free && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q;
					end
					if (older) begin
						best_q <= age;
						pick_q <= idx_q;
					end
					ip_q <= req_q.peer_ip;
					if (hit) begin
						act_q   <= prl_pkg::ACT_REFRESH;
						slot_q  <= idx_q;
						state_q <= S_EMIT;
					end else if (last_idx) begin
						act_q            <= choice_free ? prl_pkg::ACT_FILL : prl_pkg::ACT_EVICT;
						slot_q           <= choice;
						valid_q[choice]  <= 1'b1;
						state_q          <= S_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_PRUNE: begin
					// drop the entry under the index if it has expired
					if (valid_q[idx_q] && expired) begin
						valid_q[idx_q] <= 1'b0;
					end
					if (last_idx) begin
						act_q   <= prl_pkg::ACT_PRUNE;
						slot_q  <= '0;
						ip_q    <= '0;
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_LIST: begin
					// transfer one result per valid slot
					if (valid_q[idx_q]) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.action      <= prl_pkg::ACT_ENTRY;
						rsp_q.slot        <= prl_pkg::SLOT_W'(idx_q);
						rsp_q.out_ip      <= cur_addr;
						rsp_q.valid_count <= count;
						rsp_q.last        <= !more_above;
					end
					if (last_idx || (valid_q[idx_q] && !more_above)) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EMIT: begin
					rsp_valid_q       <= 1'b1;
					rsp_q.action      <= act_q;
					rsp_q.slot        <= prl_pkg::SLOT_W'(slot_q);
					rsp_q.out_ip      <= ip_q;
					rsp_q.valid_count <= count;
					rsp_q.last        <= 1'b1;
					state_q           <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* verif/tb_peer_registry_ttl_lru.sv */
// Self-checking testbench for the peer registry: directed and random commands against a table model.
`timescale 1ns / 100ps

module tb_peer_registry_ttl_lru;

	// Command code with no meaning to the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int POOL_SIZE = 12;

	// Table model plus the results it still owes
	class registry_scoreboard;
		logic [31:0]     ttl_ms;
		bit              peer_valid[prl_pkg::NUM_SLOTS];
		logic [31:0]     peer_addr[prl_pkg::NUM_SLOTS];
		logic [31:0]     peer_seen[prl_pkg::NUM_SLOTS];
		prl_pkg::rsp_t   rsp_due[$];
		int              mismatch_count;

		function new();
			ttl_ms = 32'd5000;
			mismatch_count = 0;
			for (int i = 0; i < prl_pkg::NUM_SLOTS; i++) begin
				peer_valid[i] = 1'b0;
				peer_addr[i] = '0;
				peer_seen[i] = '0;
			end
		endfunction

		function int live_count();
			int n;
			n = 0;
			for (int i = 0; i < prl_pkg::NUM_SLOTS; i++)
				if (peer_valid[i])
					n++;
			return n;
		endfunction

		function bit aged_out(int i, logic [31:0] now);
			logic [31:0] age;
			age = now - peer_seen[i];
			return age > ttl_ms;
		endfunction

		function void owe(prl_pkg::action_t act, int slot, logic [31:0] ip, bit fin);
			prl_pkg::rsp_t r;
			r.action = act;
			r.slot = slot[prl_pkg::SLOT_W-1:0];
			r.out_ip = ip;
			r.valid_count = prl_pkg::CNT_W'(live_count());
			r.last = fin;
			rsp_due.push_back(r);
		endfunction

		function void claim(int i, prl_pkg::req_t r);
			peer_addr[i] = r.peer_ip;
			peer_seen[i] = r.now_ms;
			peer_valid[i] = 1'b1;
		endfunction

		// Apply one accepted command to the table and queue its results
		function void note_command(prl_pkg::req_t r);
			int hit;
			int pick;
			int total;
			int k;
			logic [31:0] age;
			logic [31:0] best;
			hit = -1;
			case (r.cmd)
				prl_pkg::CMD_REGISTER: begin
					for (int i = 0; i < prl_pkg::NUM_SLOTS; i++)
						if (hit < 0 && peer_valid[i] && peer_addr[i] == r.peer_ip)
							hit = i;
					if (hit >= 0) begin
						peer_seen[hit] = r.now_ms;
						owe(prl_pkg::ACT_REFRESH, hit, r.peer_ip, 1'b1);
					end else begin
						for (int i = 0; i < prl_pkg::NUM_SLOTS; i++)
							if (hit < 0 && (!peer_valid[i] || aged_out(i, r.now_ms)))
								hit = i;
						if (hit >= 0) begin
							claim(hit, r);
							owe(prl_pkg::ACT_FILL, hit, r.peer_ip, 1'b1);
						end else begin
							// Evict the greatest wrapped age, lowest index on ties
							pick = 0;
							best = '0;
							for (int i = 0; i < prl_pkg::NUM_SLOTS; i++) begin
								age = r.now_ms - peer_seen[i];
								if (age > best) begin
									best = age;
									pick = i;
								end
							end
							claim(pick, r);
							owe(prl_pkg::ACT_EVICT, pick, r.peer_ip, 1'b1);
						end
					end
				end
				prl_pkg::CMD_PRUNE: begin
					for (int i = 0; i < prl_pkg::NUM_SLOTS; i++)
						if (peer_valid[i] && aged_out(i, r.now_ms))
							peer_valid[i] = 1'b0;
					owe(prl_pkg::ACT_PRUNE, 0, '0, 1'b1);
				end
				prl_pkg::CMD_LIST: begin
					total = live_count();
					k = 0;
					if (total == 0)
						owe(prl_pkg::ACT_EMPTY, 0, '0, 1'b1);
					for (int i = 0; i < prl_pkg::NUM_SLOTS; i++)
						if (peer_valid[i]) begin
							k++;
							owe(prl_pkg::ACT_ENTRY, i, peer_addr[i], k == total);
						end
				end
				default: ;
			endcase
		endfunction

		// Compare one result with the oldest owed one
		function void check_result(prl_pkg::rsp_t got);
			prl_pkg::rsp_t want;
			if (rsp_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: act=%0d slot=%0d ip=%h count=%0d last=%b",
						got.action, got.slot, got.out_ip, got.valid_count, got.last);
			end else begin
				want = rsp_due.pop_front();
				if (got.action !== want.action || got.slot !== want.slot ||
						got.out_ip !== want.out_ip || got.valid_count !== want.valid_count ||
						got.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected act=%0d slot=%0d ip=%h count=%0d last=%b, %s",
							want.action, want.slot, want.out_ip, want.valid_count, want.last,
							$sformatf("got act=%0d slot=%0d ip=%h count=%0d last=%b",
							got.action, got.slot, got.out_ip, got.valid_count, got.last));
				end
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	prl_pkg::req_t req;
	logic          cfg_we;
	logic [31:0]   cfg_wdata;
	logic          rsp_valid;
	prl_pkg::rsp_t rsp;

	registry_scoreboard sb;
	logic [31:0] addr_pool[POOL_SIZE];
	logic [31:0] clock_ms;
	bit          gaps_on;

	peer_registry_ttl_lru uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Check results first, then note a command transfer taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid)
				sb.check_result(rsp);
			if (start && !busy)
				sb.note_command(req);
		end
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Hold a command on the port until the block takes it
	task automatic drive_command(input logic [1:0] cmd, input logic [31:0] ip,
			input logic [31:0] now);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start <= 1'b1;
		req.cmd <= cmd;
		req.peer_ip <= ip;
		req.now_ms <= now;
		do @(posedge clk); while (busy);
	endtask

	// Drain the block, let a dropped command finish, then write the expiry age
	task automatic write_ttl(input logic [31:0] value);
		start <= 1'b0;
		do @(posedge clk); while (sb.rsp_due.size() != 0 || busy);
		repeat (prl_pkg::NUM_SLOTS + 4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.ttl_ms = value;
	endtask

	// Advance the time stamp in steps scaled to the current expiry age
	function automatic logic [31:0] advance_clock();
		logic [31:0] span;
		span = (sb.ttl_ms > 32'd2_000_000) ? 32'd2_000_000 : sb.ttl_ms / 4 + 1;
		case ($urandom_range(0, 9))
			0: ;
			1, 2, 3, 4, 5: clock_ms = clock_ms + $urandom_range(0, span);
			6: clock_ms = clock_ms + sb.ttl_ms;
			7: clock_ms = clock_ms + sb.ttl_ms + 1;
			8: clock_ms = clock_ms + $urandom_range(0, span * 4);
			default: clock_ms = $urandom;
		endcase
		return clock_ms;
	endfunction

	task automatic run_random(input int count, input bit quiet);
		int sel;
		logic [1:0] cmd;
		logic [31:0] ip;
		logic [31:0] now;
		for (int n = 0; n < count; n++) begin
			if (n % 16 == 0)
				gaps_on = !quiet && ($urandom_range(0, 2) != 0);
			sel = $urandom_range(0, 99);
			if ($urandom_range(0, 9) < 7)
				ip = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				ip = $urandom;
			now = advance_clock();
			if (sel < 60)
				cmd = prl_pkg::CMD_REGISTER;
			else if (sel < 72)
				cmd = prl_pkg::CMD_PRUNE;
			else if (sel < 92)
				cmd = prl_pkg::CMD_LIST;
			else
				cmd = CMD_UNUSED;
			drive_command(cmd, ip, now);
		end
	endtask

	initial begin
		logic [31:0] base;
		logic [31:0] first_ips[prl_pkg::NUM_SLOTS];
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		gaps_on = 1'b1;
		addr_pool[0] = 32'h0000_0000;
		addr_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom;
		first_ips[0] = 32'h0000_0000;
		first_ips[1] = 32'hFFFF_FFFF;
		first_ips[2] = 32'h0000_0001;
		first_ips[3] = 32'h8000_0000;
		first_ips[4] = 32'h7FFF_FFFF;
		for (int i = 5; i < prl_pkg::NUM_SLOTS; i++)
			first_ips[i] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, unknown code, full table, ties, TTL boundary, wrap
		base = 32'd1000;
		drive_command(prl_pkg::CMD_LIST, $urandom, $urandom);
		drive_command(prl_pkg::CMD_PRUNE, $urandom, base);
		drive_command(CMD_UNUSED, $urandom, $urandom);
		for (int i = 0; i < prl_pkg::NUM_SLOTS; i++)
			drive_command(prl_pkg::CMD_REGISTER, first_ips[i], base);
		drive_command(prl_pkg::CMD_REGISTER, 32'h0A0B_0C0D, base);
		drive_command(prl_pkg::CMD_REGISTER, 32'hFFFF_FFFF, base + 3);
		drive_command(prl_pkg::CMD_LIST, $urandom, $urandom);
		drive_command(prl_pkg::CMD_REGISTER, 32'h1234_5678, base + 5000);
		drive_command(prl_pkg::CMD_REGISTER, 32'h5555_AAAA, base + 5001);
		drive_command(prl_pkg::CMD_PRUNE, $urandom, base + 5001);
		drive_command(prl_pkg::CMD_LIST, $urandom, $urandom);
		drive_command(prl_pkg::CMD_REGISTER, 32'hAAAA_5555, 32'hFFFF_FFF0);
		drive_command(prl_pkg::CMD_REGISTER, 32'hAAAA_5555, 32'h0000_0010);
		drive_command(prl_pkg::CMD_PRUNE, $urandom, 32'h0000_0010);
		drive_command(prl_pkg::CMD_LIST, $urandom, $urandom);

		// Random phases across expiry ages, extremes first, no gaps at the end
		clock_ms = $urandom;
		write_ttl(32'd0);
		run_random(80, 1'b0);
		write_ttl(32'hFFFF_FFFF);
		run_random(80, 1'b0);
		write_ttl($urandom_range(1, 300));
		run_random(80, 1'b0);
		write_ttl($urandom_range(1000, 20000));
		run_random(80, 1'b0);
		write_ttl(32'd5000);
		run_random(90, 1'b1);

		// Drain, then allow a dropped command to run out
		start <= 1'b0;
		do @(posedge clk); while (sb.rsp_due.size() != 0);
		repeat (2 * prl_pkg::NUM_SLOTS + 4) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.rsp_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* peer_registry_ttl_lru.f */
hw/rtl/prl_pkg.sv
hw/rtl/peer_registry_ttl_lru.sv
verif/tb_peer_registry_ttl_lru.sv
